// File: design/xoshiro_range_random_core_assert.svh
// ----------------------------------------------------------------------------
// xoshiro_range_random_core_assert.svh
// Assertion macros for the checker file of the range random core.
// ----------------------------------------------------------------------------
`ifndef XOSHIRO_RANGE_RANDOM_CORE_ASSERT_SVH
`define XOSHIRO_RANGE_RANDOM_CORE_ASSERT_SVH

// Check a property on the rising clock, skipped while reset is active.
`define XRR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on the rising clock, also while reset is active.
`define XRR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/xrr_pkg.sv
// ----------------------------------------------------------------------------
// xrr_pkg
// Types, constants and generator functions of the range random core.
// ----------------------------------------------------------------------------
package xrr_pkg;

  localparam int ValueW = 32;
  localparam int DiffW  = 33;
  localparam int WordW  = 64;

  localparam int SpreadRoundsDefault = 16;
  localparam int ReqQueueDepth       = 2;

  // Generator constants
  localparam int StateShift = 17;
  localparam int StateRot   = 45;
  localparam int OutRot     = 7;

  localparam logic [WordW-1:0] SeedWordOne = 64'h0000_0000_0000_00ff;

  // Configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgSeedFirst  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSeedSecond = 1'b1;

  typedef logic [3:0][WordW-1:0] gen_state_t;

  // Loaded state before the spread rounds: word one is 0xff, the seeds are 0
  localparam gen_state_t ResetState = {64'd0, 64'd0, SeedWordOne, 64'd0};

  typedef enum logic [1:0] {
    REQ_DRAW   = 2'd0,
    REQ_FIXED  = 2'd1,
    REQ_RESEED = 2'd2
  } req_kind_e;

  typedef struct packed {
    req_kind_e             kind;
    logic [ValueW-1:0]     lo;
    logic [DiffW-1:0]      diff;
    logic [DiffW-1:0]      mask;
  } req_t;

  typedef enum logic [3:0] {
    ST_INIT   = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_DRAW   = 4'b0100,
    ST_SPREAD = 4'b1000
  } back_state_e;

  function automatic logic [WordW-1:0] rotl64(input logic [WordW-1:0] v, input int k);
    rotl64 = (v << k) | (v >> (WordW - k));
  endfunction

  function automatic logic [WordW-1:0] times5(input logic [WordW-1:0] v);
    times5 = v + {v[WordW-3:0], 2'b00};
  endfunction

  // One xoshiro256 state advance
  function automatic gen_state_t gen_step(input gen_state_t s);
    logic [WordW-1:0] w2;
    logic [WordW-1:0] w3;
    gen_state_t       n;
    w2   = s[2] ^ s[0];
    w3   = s[3] ^ s[1];
    n[0] = s[0] ^ w3;
    n[1] = s[1] ^ w2;
    n[2] = w2 ^ (s[1] << StateShift);
    n[3] = rotl64(w3, StateRot);
    gen_step = n;
  endfunction

endpackage

// File: design/xrr_front.sv
// ----------------------------------------------------------------------------
// xrr_front
// Accepts requests, orders the bounds and computes span and mask.
// ----------------------------------------------------------------------------
module xrr_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic signed [xrr_pkg::ValueW-1:0] bound_one_i,
  input  logic signed [xrr_pkg::ValueW-1:0] bound_two_i,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output xrr_pkg::req_t                   push_req_o
);

  logic                          hold_valid_q;
  xrr_pkg::req_kind_e            kind_q, kind_d;
  logic [xrr_pkg::ValueW-1:0]    lo_q, lo_d;
  logic [xrr_pkg::DiffW-1:0]     diff_q, diff_d;
  logic [xrr_pkg::DiffW-1:0]     mask;
  logic                          accept;
  logic signed [xrr_pkg::ValueW-1:0] lo_s, hi_s;

  assign in_ready_o = !hold_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the request and take the exact span
  always_comb begin
    lo_s = (bound_one_i < bound_two_i) ? bound_one_i : bound_two_i;
    hi_s = (bound_one_i < bound_two_i) ? bound_two_i : bound_one_i;
    lo_d   = lo_s;
    diff_d = {hi_s[xrr_pkg::ValueW-1], hi_s} - {lo_s[xrr_pkg::ValueW-1], lo_s};
    if (mode_i) begin
      kind_d = xrr_pkg::REQ_RESEED;
      lo_d   = '0;
      diff_d = '0;
    end else if (bound_one_i == bound_two_i) begin
      kind_d = xrr_pkg::REQ_FIXED;
      lo_d   = bound_one_i;
      diff_d = '0;
    end else begin
      kind_d = xrr_pkg::REQ_DRAW;
    end
  end

  // Hold the valid flag of the staging register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      hold_valid_q <= in_valid_i;
    end
  end

  // Hold the classified request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_d;
      lo_q   <= lo_d;
      diff_q <= diff_d;
    end
  end

  // Smear the span into the smallest all-ones mask that covers it
  always_comb begin
    mask = diff_q;
    for (int k = 0; k < 6; k++) begin
      mask = mask | (mask >> (1 << k));
    end
  end

  assign push_valid_o    = hold_valid_q;
  assign push_req_o.kind = kind_q;
  assign push_req_o.lo   = lo_q;
  assign push_req_o.diff = diff_q;
  assign push_req_o.mask = mask;

endmodule

// File: design/xrr_queue.sv
// ----------------------------------------------------------------------------
// xrr_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module xrr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  xrr_pkg::req_t push_req_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output xrr_pkg::req_t pop_req_o
);

  localparam int Depth = xrr_pkg::ReqQueueDepth;
  localparam int PtrW  = (Depth < 2) ? 1 : $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  xrr_pkg::req_t   entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_req_o    = entries_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // Store pushed requests
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

// File: design/xrr_back.sv
// ----------------------------------------------------------------------------
// xrr_back
// Generator state, rejection loop, reseed sequencer and result register.
// ----------------------------------------------------------------------------
module xrr_back #(
  parameter int SPREAD_ROUNDS = xrr_pkg::SpreadRoundsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  output logic                              req_ready_o,
  input  xrr_pkg::req_t                     req_i,
  input  logic [xrr_pkg::WordW-1:0]         seed_first_i,
  input  logic [xrr_pkg::WordW-1:0]         seed_second_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [xrr_pkg::ValueW-1:0] value_o
);

  localparam int CntW = (SPREAD_ROUNDS < 1) ? 1 : $clog2(SPREAD_ROUNDS + 1);
  localparam int DiffW = xrr_pkg::DiffW;

  xrr_pkg::back_state_e        state_q, state_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  xrr_pkg::gen_state_t         gen_q, gen_d, gen_next;
  logic [xrr_pkg::WordW-1:0]   m5_q, m5_d;
  logic [xrr_pkg::WordW-1:0]   rot;
  logic [DiffW-1:0]            word;
  logic [DiffW-1:0]            masked;
  logic                        fits;
  logic [xrr_pkg::ValueW-1:0]  lo_q;
  logic [DiffW-1:0]            diff_q, mask_q;
  logic                        take;
  logic                        out_valid_q, out_valid_d;
  logic [xrr_pkg::ValueW-1:0]  value_q, value_d;
  logic                        load_value;
  logic                        slot_free;

  // Low bits of the scrambled output: rotl(s1 * 5, 7) * 9
  assign rot      = xrr_pkg::rotl64(m5_q, xrr_pkg::OutRot);
  assign word     = rot[DiffW-1:0] + {rot[DiffW-4:0], 3'b000};
  assign masked   = word & mask_q;
  assign fits     = (masked <= diff_q);
  assign gen_next = xrr_pkg::gen_step(gen_q);

  assign slot_free   = !out_valid_q || out_ready_i;
  assign req_ready_o = (state_q == xrr_pkg::ST_IDLE) && slot_free;
  assign take        = req_valid_i && req_ready_o;

  // Sequence requests through the generator
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    gen_d       = gen_q;
    m5_d        = m5_q;
    out_valid_d = out_valid_q && !out_ready_i;
    value_d     = value_q;
    load_value  = 1'b0;
    unique case (state_q)
      xrr_pkg::ST_INIT: begin
        gen_d = gen_next;
        m5_d  = xrr_pkg::times5(gen_next[1]);
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = xrr_pkg::ST_IDLE;
        end
      end
      xrr_pkg::ST_IDLE: begin
        if (take) begin
          unique case (req_i.kind)
            xrr_pkg::REQ_FIXED: begin
              out_valid_d = 1'b1;
              value_d     = req_i.lo;
            end
            xrr_pkg::REQ_RESEED: begin
              gen_d[0] = seed_first_i;
              gen_d[1] = xrr_pkg::SeedWordOne;
              gen_d[2] = seed_second_i;
              gen_d[3] = '0;
              m5_d     = xrr_pkg::times5(xrr_pkg::SeedWordOne);
              if (SPREAD_ROUNDS == 0) begin
                out_valid_d = 1'b1;
                value_d     = '0;
              end else begin
                cnt_d   = CntW'(SPREAD_ROUNDS);
                state_d = xrr_pkg::ST_SPREAD;
              end
            end
            xrr_pkg::REQ_DRAW: begin
              load_value = 1'b1;
              state_d    = xrr_pkg::ST_DRAW;
            end
            default: begin
              out_valid_d = 1'b1;
              value_d     = '0;
            end
          endcase
        end
      end
      xrr_pkg::ST_DRAW: begin
        gen_d = gen_next;
        m5_d  = xrr_pkg::times5(gen_next[1]);
        if (fits) begin
          out_valid_d = 1'b1;
          value_d     = lo_q + masked[xrr_pkg::ValueW-1:0];
          state_d     = xrr_pkg::ST_IDLE;
        end
      end
      xrr_pkg::ST_SPREAD: begin
        gen_d = gen_next;
        m5_d  = xrr_pkg::times5(gen_next[1]);
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          out_valid_d = 1'b1;
          value_d     = '0;
          state_d     = xrr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = xrr_pkg::ST_IDLE;
      end
    endcase
  end

  // Hold control and generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= (SPREAD_ROUNDS == 0) ? xrr_pkg::ST_IDLE : xrr_pkg::ST_INIT;
      cnt_q       <= CntW'(SPREAD_ROUNDS);
      gen_q       <= xrr_pkg::ResetState;
      m5_q        <= xrr_pkg::times5(xrr_pkg::SeedWordOne);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      gen_q       <= gen_d;
      m5_q        <= m5_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the draw operands and the result
  always_ff @(posedge clk_i) begin
    if (load_value) begin
      lo_q   <= req_i.lo;
      diff_q <= req_i.diff;
      mask_q <= req_i.mask;
    end
    value_q <= value_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

endmodule

// File: design/xoshiro_range_random_core.sv
// ----------------------------------------------------------------------------
// xoshiro_range_random_core
// Uniform random integers in an inclusive signed range from xoshiro256**.
// ----------------------------------------------------------------------------
// A request passes a front stage that orders the bounds and builds the span
// mask, then a two-entry queue, then the generator unit, which makes one
// generator step per cycle while it draws or spreads. The front stage and
// the queue each register a request before the generator unit sees it. A
// draw with equal bounds is answered without advancing the generator; any
// other draw loads its operands, then tries one candidate word per step, on
// average less than two, until a masked word fits the span. A reseed loads
// the seeds, runs SPREAD_ROUNDS spread rounds and returns 0. After reset
// the generator unit runs SPREAD_ROUNDS rounds of initial spread before it
// serves its first request; requests are accepted into the front stage and
// queue meanwhile. The user must write the seed registers on the
// configuration port only while the block is idle; it is not enforced.
module xoshiro_range_random_core #(
  parameter int SPREAD_ROUNDS = xrr_pkg::SpreadRoundsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [xrr_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [xrr_pkg::WordW-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               mode_i,
  input  logic signed [xrr_pkg::ValueW-1:0]  bound_one_i,
  input  logic signed [xrr_pkg::ValueW-1:0]  bound_two_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [xrr_pkg::ValueW-1:0]  value_o
);

  logic [xrr_pkg::WordW-1:0] seed_first_q, seed_second_q;
  logic                      push_valid, push_ready;
  xrr_pkg::req_t             push_req;
  logic                      pop_valid, pop_ready;
  xrr_pkg::req_t             pop_req;

  // Write the seed registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_first_q  <= '0;
      seed_second_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        xrr_pkg::CfgSeedFirst:  seed_first_q  <= cfg_wdata_i;
        xrr_pkg::CfgSeedSecond: seed_second_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  xrr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .bound_one_i  (bound_one_i),
    .bound_two_i  (bound_two_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_req_o   (push_req)
  );

  xrr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_req_i   (push_req),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_req_o    (pop_req)
  );

  xrr_back #(
    .SPREAD_ROUNDS (SPREAD_ROUNDS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (pop_valid),
    .req_ready_o   (pop_ready),
    .req_i         (pop_req),
    .seed_first_i  (seed_first_q),
    .seed_second_i (seed_second_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o)
  );

endmodule

// File: design/xrr_checker.sv
// ----------------------------------------------------------------------------
// xrr_checker
// Port-level checks of the range random core, bound to the top level.
// ----------------------------------------------------------------------------
`include "xoshiro_range_random_core_assert.svh"

module xrr_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [xrr_pkg::ValueW-1:0] value_o
);

  logic [3:0] pend_q;
  logic       in_take, out_take;

  assign in_take  = in_valid_i && in_ready_o;
  assign out_take = out_valid_o && out_ready_i;

  // Track requests accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_take && !out_take) begin
      pend_q <= pend_q + 4'd1;
    end else if (out_take && !in_take) begin
      pend_q <= pend_q - 4'd1;
    end
  end

  `XRR_ASSERT(a_out_holds, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")
  `XRR_ASSERT(a_value_holds, out_valid_o && !out_ready_i |=> $stable(value_o), "result changed while stalled")
  `XRR_ASSERT(a_no_spurious, out_valid_o |-> pend_q != 4'd0, "result without a pending request")
  `XRR_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result shown during reset")

endmodule

bind xoshiro_range_random_core xrr_checker u_xrr_checker (.*);
